// ===== sv/bir_pkg.sv =====
`default_nettype none

package bir_pkg;

  localparam int CH_W       = 16;
  localparam int NUM_CH     = 3;
  localparam int POS_W      = 12;
  localparam int SRC_SZ_W   = 9;
  localparam int DST_SZ_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0] pix_t;

endpackage

`default_nettype wire

// ===== sv/bir_lerp.sv =====
`default_nettype none

module bir_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  bir_pkg::chan_t   v0,
  input  bir_pkg::chan_t   v1,
  input  logic [FRAC_BITS:0] w,
  output bir_pkg::chan_t   res
);
  import bir_pkg::*;

  localparam int PROD_W = FRAC_BITS + 1 + CH_W;

  logic              neg;
  chan_t             diff;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r;
  chan_t             v0_r;
  logic [PROD_W:0]   rnd;
  chan_t             q;
  chan_t             res_nxt;
  chan_t             res_r;

  assign neg      = v1 < v0;
  assign diff     = neg ? v0 - v1 : v1 - v0;
  assign prod_nxt = PROD_W'(w) * PROD_W'(diff);

  // floor of a negative step: round the magnitude up
  assign rnd = neg_r ? {1'b0, prod_r} + (PROD_W+1)'({FRAC_BITS{1'b1}}) : {1'b0, prod_r};
  assign q       = rnd[FRAC_BITS +: CH_W];
  assign res_nxt = neg_r ? v0_r - q : v0_r + q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      neg_r  <= neg;
      v0_r   <= v0;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== sv/bir_div.sv =====
`default_nettype none

module bir_div #(
  parameter int N_W = 25,
  parameter int D_W = 13
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [N_W-1:0] quot
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   q_r;
  logic [N_W-1:0]   q_nxt;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   rem_nxt;
  logic [D_W-1:0]   d_r;
  logic [D_W:0]     sh;
  logic             ge;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  // restoring division, one quotient bit per cycle
  assign sh      = {rem_r, q_r[N_W-1]};
  assign ge      = sh >= {1'b0, d_r};
  assign rem_nxt = ge ? D_W'(sh - {1'b0, d_r}) : D_W'(sh);
  assign q_nxt   = {q_r[N_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(N_W);
    end else if (busy_r) begin
      busy_r <= cnt_r != CNT_W'(1);
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = busy_r && (cnt_r == CNT_W'(1));
  assign quot = q_nxt;

endmodule

`default_nettype wire

// ===== sv/bilinear_image_resampler.sv =====
// Bilinear RGB scaler over a source frame held in four banked on-chip memories.
// Input channel (in_valid/in_ready): in_op = write stores in_red/green/blue at
// source (in_pos_x, in_pos_y), ignored outside the source size, no response.
// in_op = read asks for destination pixel (in_pos_x, in_pos_y); one response
// with the three interpolated channels comes out on out_valid/out_ready.
// Throughput: one request per cycle unless stalled by out_ready or by a ratio
// recompute. The four neighbours come from four banks split by row and column
// parity, so one read per bank per cycle suffices. A read request passes the
// multiply, the memory read and two lerp stages before out_valid rises.
// A stalled receiver freezes the whole pipeline and holds in_ready low.
// Sizes are set on the cfg_ port. After any register write the src/dst ratios
// are recomputed by serial dividers; in_ready stays low until both finish.
// Reset loads 256 x 256 -> 256 x 256 with the ratios preset, so no wait after
// reset. Source memory is not cleared.
`default_nettype none

module bilinear_image_resampler #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int FRAC_BITS      = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [bir_pkg::POS_W-1:0]       in_pos_x,
  input  logic [bir_pkg::POS_W-1:0]       in_pos_y,
  input  bir_pkg::chan_t                  in_red,
  input  bir_pkg::chan_t                  in_green,
  input  bir_pkg::chan_t                  in_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bir_pkg::chan_t                  out_red,
  output bir_pkg::chan_t                  out_green,
  output bir_pkg::chan_t                  out_blue,
  input  logic                            cfg_wr_en,
  input  logic [bir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bir_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import bir_pkg::*;

  localparam int RATIO_W = SRC_SZ_W + FRAC_BITS;
  localparam int CX_W    = POS_W + RATIO_W;
  localparam int BF_W    = CX_W - FRAC_BITS;
  localparam int W_W     = FRAC_BITS + 1;
  localparam int BX_W    = $clog2(MAX_SRC_WIDTH);
  localparam int BY_W    = $clog2(MAX_SRC_HEIGHT);
  localparam int XI_RAW  = $clog2((MAX_SRC_WIDTH + 1) / 2);
  localparam int YI_RAW  = $clog2((MAX_SRC_HEIGHT + 1) / 2);
  localparam int XI_W    = (XI_RAW < 1) ? 1 : XI_RAW;
  localparam int YI_W    = (YI_RAW < 1) ? 1 : YI_RAW;
  localparam int AW      = XI_W + YI_W;
  localparam int BANK_DEPTH = 2 ** AW;
  localparam int SZ_MAX  = (1 << SRC_SZ_W) - 1;
  localparam int SW_CAP  = (MAX_SRC_WIDTH  > SZ_MAX) ? SZ_MAX : MAX_SRC_WIDTH;
  localparam int SH_CAP  = (MAX_SRC_HEIGHT > SZ_MAX) ? SZ_MAX : MAX_SRC_HEIGHT;
  localparam int SW_RST  = (MAX_SRC_WIDTH  < 256) ? MAX_SRC_WIDTH  : 256;
  localparam int SH_RST  = (MAX_SRC_HEIGHT < 256) ? MAX_SRC_HEIGHT : 256;
  localparam longint RATIO_RST_X = (longint'(SW_RST) << FRAC_BITS) / 256;
  localparam longint RATIO_RST_Y = (longint'(SH_RST) << FRAC_BITS) / 256;

  // configuration
  logic [SRC_SZ_W-1:0] src_width_r, src_height_r;
  logic [DST_SZ_W-1:0] dst_width_r, dst_height_r;
  logic [SRC_SZ_W-1:0] sw_eff, sh_eff, sw_m1, sh_m1;
  logic [DST_SZ_W-1:0] dw_eff, dh_eff;
  logic [RATIO_W-1:0]  ratio_x_r, ratio_y_r;
  logic [RATIO_W-1:0]  quot_x, quot_y;
  logic                start_r;
  logic                busy_x, busy_y, done_x, done_y;
  logic                cfg_busy;

  // pipeline
  logic                adv;
  logic                acc;
  logic                s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;
  logic                s1_op_r;
  logic [POS_W-1:0]    s1_px_r, s1_py_r;
  pix_t                s1_pix_r;
  logic [CX_W-1:0]     s1_cx_nxt, s1_cy_nxt, s1_cx_r, s1_cy_r;

  logic [BF_W-1:0]     bfx, bfy;
  logic                clamp_x, clamp_y;
  logic [BX_W-1:0]     bx;
  logic [BY_W-1:0]     by;
  logic [W_W-1:0]      wx, wy;
  logic [XI_W-1:0]     xi0, xi1, wr_xi;
  logic [YI_W-1:0]     yi0, yi1, wr_yi;
  logic [AW-1:0]       rd_addr [4];
  logic [AW-1:0]       wr_addr;
  logic                wr_ok;
  logic [3:0]          bank_we;

  pix_t                mem [4][BANK_DEPTH];
  pix_t                rd_r [4];

  logic [W_W-1:0]      s2_wx_r, s2_wy_r, s3_wy_r, s4_wy_r;
  logic                s2_bx0_r, s2_by0_r;
  pix_t                a00, a01, a10, a11;
  wire pix_t           h_top;
  wire pix_t           h_bot;
  wire pix_t           v_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_SZ_W'(256);
      src_height_r <= SRC_SZ_W'(256);
      dst_width_r  <= DST_SZ_W'(256);
      dst_height_r <= DST_SZ_W'(256);
      start_r      <= 1'b0;
    end else begin
      start_r <= cfg_wr_en;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_width_r  <= cfg_wr_data[SRC_SZ_W-1:0];
          REG_SRC_HEIGHT: src_height_r <= cfg_wr_data[SRC_SZ_W-1:0];
          REG_DST_WIDTH:  dst_width_r  <= cfg_wr_data[DST_SZ_W-1:0];
          REG_DST_HEIGHT: dst_height_r <= cfg_wr_data[DST_SZ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign sw_eff = (src_width_r < SRC_SZ_W'(2)) ? SRC_SZ_W'(2) :
                  (src_width_r > SRC_SZ_W'(SW_CAP)) ? SRC_SZ_W'(SW_CAP) : src_width_r;
  assign sh_eff = (src_height_r < SRC_SZ_W'(2)) ? SRC_SZ_W'(2) :
                  (src_height_r > SRC_SZ_W'(SH_CAP)) ? SRC_SZ_W'(SH_CAP) : src_height_r;
  assign dw_eff = (dst_width_r  == '0) ? DST_SZ_W'(1) : dst_width_r;
  assign dh_eff = (dst_height_r == '0) ? DST_SZ_W'(1) : dst_height_r;
  assign sw_m1  = sw_eff - SRC_SZ_W'(1);
  assign sh_m1  = sh_eff - SRC_SZ_W'(1);

  bir_div #(.N_W(RATIO_W), .D_W(DST_SZ_W)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend ({sw_eff, {FRAC_BITS{1'b0}}}),
    .divisor  (dw_eff),
    .busy     (busy_x),
    .done     (done_x),
    .quot     (quot_x)
  );

  bir_div #(.N_W(RATIO_W), .D_W(DST_SZ_W)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend ({sh_eff, {FRAC_BITS{1'b0}}}),
    .divisor  (dh_eff),
    .busy     (busy_y),
    .done     (done_y),
    .quot     (quot_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_x_r <= RATIO_W'(RATIO_RST_X);
      ratio_y_r <= RATIO_W'(RATIO_RST_Y);
    end else begin
      if (done_x) ratio_x_r <= quot_x;
      if (done_y) ratio_y_r <= quot_y;
    end
  end

  assign cfg_busy = start_r || busy_x || busy_y;

  // handshake
  assign adv       = !s6_v_r || out_ready;
  assign in_ready  = adv && !cfg_busy;
  assign acc       = in_valid && in_ready;
  assign out_valid = s6_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r && (s1_op_r == OP_READ);
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  // stage 1: source coordinates
  assign s1_cx_nxt = CX_W'(in_pos_x) * CX_W'(ratio_x_r);
  assign s1_cy_nxt = CX_W'(in_pos_y) * CX_W'(ratio_y_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r  <= in_op;
      s1_px_r  <= in_pos_x;
      s1_py_r  <= in_pos_y;
      s1_pix_r[CH_RED]   <= in_red;
      s1_pix_r[CH_GREEN] <= in_green;
      s1_pix_r[CH_BLUE]  <= in_blue;
      s1_cx_r  <= s1_cx_nxt;
      s1_cy_r  <= s1_cy_nxt;
    end
  end

  // edge rule: base clamps to size-2 with full weight
  assign bfx     = s1_cx_r[CX_W-1:FRAC_BITS];
  assign bfy     = s1_cy_r[CX_W-1:FRAC_BITS];
  assign clamp_x = bfx >= BF_W'(sw_m1);
  assign clamp_y = bfy >= BF_W'(sh_m1);
  assign bx = clamp_x ? BX_W'(sw_eff - SRC_SZ_W'(2)) : bfx[BX_W-1:0];
  assign by = clamp_y ? BY_W'(sh_eff - SRC_SZ_W'(2)) : bfy[BY_W-1:0];
  assign wx = clamp_x ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, s1_cx_r[FRAC_BITS-1:0]};
  assign wy = clamp_y ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, s1_cy_r[FRAC_BITS-1:0]};

  // bank = {row parity, column parity}; odd banks hold base>>1, even ones round up
  assign xi1 = XI_W'(bx >> 1);
  assign yi1 = YI_W'(by >> 1);
  assign xi0 = xi1 + XI_W'(bx[0]);
  assign yi0 = yi1 + YI_W'(by[0]);
  assign rd_addr[0] = {yi0, xi0};
  assign rd_addr[1] = {yi0, xi1};
  assign rd_addr[2] = {yi1, xi0};
  assign rd_addr[3] = {yi1, xi1};

  assign wr_ok   = (s1_px_r < POS_W'(sw_eff)) && (s1_py_r < POS_W'(sh_eff));
  assign wr_xi   = XI_W'(s1_px_r >> 1);
  assign wr_yi   = YI_W'(s1_py_r >> 1);
  assign wr_addr = {wr_yi, wr_xi};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = adv && s1_v_r && (s1_op_r == OP_WRITE) && wr_ok &&
                   ({s1_py_r[0], s1_px_r[0]} == 2'(b));
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      if (bank_we[b]) mem[b][wr_addr] <= s1_pix_r;
      if (adv) rd_r[b] <= mem[b][rd_addr[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_wx_r  <= wx;
      s2_wy_r  <= wy;
      s2_bx0_r <= bx[0];
      s2_by0_r <= by[0];
      s3_wy_r  <= s2_wy_r;
      s4_wy_r  <= s3_wy_r;
    end
  end

  // stage 2: route banks to neighbours
  assign a00 = rd_r[{s2_by0_r, s2_bx0_r}];
  assign a01 = rd_r[{s2_by0_r, ~s2_bx0_r}];
  assign a10 = rd_r[{~s2_by0_r, s2_bx0_r}];
  assign a11 = rd_r[{~s2_by0_r, ~s2_bx0_r}];

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    bir_lerp #(.FRAC_BITS(FRAC_BITS)) u_top (
      .clk (clk),
      .en  (adv),
      .v0  (a00[c]),
      .v1  (a01[c]),
      .w   (s2_wx_r),
      .res (h_top[c])
    );

    bir_lerp #(.FRAC_BITS(FRAC_BITS)) u_bot (
      .clk (clk),
      .en  (adv),
      .v0  (a10[c]),
      .v1  (a11[c]),
      .w   (s2_wx_r),
      .res (h_bot[c])
    );

    bir_lerp #(.FRAC_BITS(FRAC_BITS)) u_vert (
      .clk (clk),
      .en  (adv),
      .v0  (h_top[c]),
      .v1  (h_bot[c]),
      .w   (s4_wy_r),
      .res (v_res[c])
    );
  end

  assign out_red   = v_res[CH_RED];
  assign out_green = v_res[CH_GREEN];
  assign out_blue  = v_res[CH_BLUE];

`ifndef SYNTH
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_ready)
    else $error("request taken while ratios are being recomputed");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_x || busy_y) |-> !in_ready)
    else $error("request taken while divider busy");

  a_base_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_op_r == OP_READ) |->
      (BF_W'(bx) < BF_W'(sw_m1)) && (BF_W'(by) < BF_W'(sh_m1)))
    else $error("neighbour base outside source frame");

  a_resp_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s5_v_r))
    else $error("response without a request in flight");
`endif

endmodule

`default_nettype wire
